/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Plain condition checked on every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

/* hdl/frdq_pkg.sv */
// ---------------------------------------------------------------------------
// frdq_pkg
// Types and constants of the flooding relay with duplicate suppression.
// ---------------------------------------------------------------------------
package frdq_pkg;

   localparam logic [1:0] KIND_RECEIVE = 2'd0;
   localparam logic [1:0] KIND_LOCAL   = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   localparam logic RESULT_DELIVER  = 1'b0;
   localparam logic RESULT_TRANSMIT = 1'b1;

   localparam logic [1:0] CSR_NODE_ADDRESS    = 2'd0;
   localparam logic [1:0] CSR_MAX_RETRANSMITS = 2'd1;
   localparam logic [1:0] CSR_SEND_PERIOD     = 2'd2;

   localparam logic [7:0] ID_WRAP_LIMIT = 8'd240;
   localparam int SEEN_WIDTH  = 29;
   localparam int QUEUE_WIDTH = 48;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] origin_addr;
      logic [7:0]  frame_id;
      logic [3:0]  hop_count;
      logic [3:0]  time_to_live;
      logic [7:0]  payload_ref;
      logic        send_accepted;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] out_origin;
      logic [7:0]  out_id;
      logic [3:0]  out_hops;
      logic [3:0]  previous_hops;
      logic [3:0]  out_ttl;
      logic [7:0]  out_payload_ref;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] origin;
      logic [7:0]  id;
      logic [3:0]  hops;
   } seen_type;

   typedef struct packed {
      logic [15:0] origin;
      logic [7:0]  id;
      logic [3:0]  hops;
      logic [3:0]  ttl;
      logic [7:0]  retx;
      logic [7:0]  pref;
   } qent_type;

endpackage

/* hdl/frdq_ram.sv */
// ---------------------------------------------------------------------------
// frdq_ram
// Single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module frdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* hdl/flood_relay_dedup_queue.sv */
// ---------------------------------------------------------------------------
// flood_relay_dedup_queue
// n-hop flooding relay: per-origin duplicate table and forwarding queue.
// ---------------------------------------------------------------------------
//  channel  direction  payload                 handshake
//  req_     in         frdq_pkg::req_type      req_valid / req_stall
//  rsp_     out        frdq_pkg::rsp_type      rsp_valid / rsp_stall
//  csr_     in         index + 16-bit data     csr_write, no wait
//
//  A received frame is scanned against the origin table one entry per cycle
//  through its read port before its result is decided and registered.
//  A re-delivery also reads and rewrites each queued entry in turn. Local
//  requests and ticks skip the table scan. After reset the table valid bits
//  are cleared entry by entry; no transaction is taken meanwhile, nor while
//  a result waits in the output register.
// ---------------------------------------------------------------------------
module flood_relay_dedup_queue #(
   parameter int SEEN_ENTRIES = 16,
   parameter int QUEUE_DEPTH  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frdq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frdq_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int SW = (SEEN_ENTRIES > 1) ? $clog2(SEEN_ENTRIES) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SCW = $clog2(SEEN_ENTRIES + 1);
   localparam logic [SW-1:0] SEEN_LAST = SW'(SEEN_ENTRIES - 1);
   localparam logic [QW-1:0] QUEUE_LAST = QW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] QUEUE_FULL = CW'(QUEUE_DEPTH);

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b0000000001,
      ST_IDLE    = 10'b0000000010,
      ST_SCAN    = 10'b0000000100,
      ST_DECIDE  = 10'b0000001000,
      ST_QSCAN   = 10'b0000010000,
      ST_QWRITE  = 10'b0000100000,
      ST_ENQ     = 10'b0001000000,
      ST_TREAD   = 10'b0010000000,
      ST_TSEND   = 10'b0100000000,
      ST_OUT     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] node_address_ff, node_address_in;
   logic [7:0]  max_retx_ff, max_retx_in;
   logic [15:0] send_period_ff, send_period_in;

   logic [QW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    local_id_ff, local_id_in;
   logic [15:0]   countdown_ff, countdown_in;
   logic          timer_ff, timer_in;

   frdq_pkg::req_type req_ff, req_in;
   frdq_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [SCW-1:0] sidx_ff, sidx_in;
   logic           rd_pend_ff, rd_pend_in;
   logic           hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [SW-1:0]  hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   frdq_pkg::seen_type hit_ent_ff, hit_ent_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [QW-1:0]  qaddr_ff, qaddr_in;

   // table RAM
   logic                         s_we;
   logic [SW-1:0]                s_waddr, s_raddr;
   frdq_pkg::seen_type           s_wdata, s_rdata;
   // queue RAM
   logic                         q_we;
   logic [QW-1:0]                q_waddr, q_raddr;
   frdq_pkg::qent_type           q_wdata, q_rdata;

   frdq_ram #(.WIDTH(frdq_pkg::SEEN_WIDTH), .DEPTH(SEEN_ENTRIES)) u_seen (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata)
   );

   frdq_ram #(.WIDTH(frdq_pkg::QUEUE_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic [QW-1:0] qinc(input logic [QW-1:0] a);
      return (a == QUEUE_LAST) ? '0 : a + QW'(1);
   endfunction

   logic          is_new;
   logic          is_redeliver;
   logic [7:0]    diff;
   logic [7:0]    ent_ttl8;
   logic [7:0]    retx_nx;
   logic          q_full;
   logic [15:0]   period_eff;

   always_comb begin
      state_in = state_ff;
      node_address_in = node_address_ff;
      max_retx_in = max_retx_ff;
      send_period_in = send_period_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      local_id_in = local_id_ff;
      countdown_in = countdown_ff;
      timer_in = timer_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      sidx_in = sidx_ff;
      rd_pend_in = rd_pend_ff;
      hit_in = hit_ff;
      free_ok_in = free_ok_ff;
      hit_idx_in = hit_idx_ff;
      free_idx_in = free_idx_ff;
      hit_ent_in = hit_ent_ff;
      k_in = k_ff;
      qaddr_in = qaddr_ff;
      s_we = 1'b0;
      s_waddr = sidx_ff[SW-1:0];
      s_wdata = '0;
      s_raddr = sidx_ff[SW-1:0];
      q_we = 1'b0;
      q_waddr = tail_ff;
      q_wdata = q_rdata;
      q_raddr = head_ff;
      q_full = (count_ff >= QUEUE_FULL);
      period_eff = (send_period_ff == 16'd0) ? 16'd1 : send_period_ff;
      is_new = 1'b0;
      is_redeliver = 1'b0;
      diff = '0;
      ent_ttl8 = '0;
      retx_nx = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (csr_index)
            frdq_pkg::CSR_NODE_ADDRESS:    node_address_in = csr_data;
            frdq_pkg::CSR_MAX_RETRANSMITS: max_retx_in = csr_data[7:0];
            frdq_pkg::CSR_SEND_PERIOD:     send_period_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            s_we = 1'b1;
            s_wdata = '0;
            if (sidx_ff[SW-1:0] == SEEN_LAST) begin
               state_in = ST_IDLE;
            end else begin
               sidx_in = sidx_ff + SCW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in = req_data;
               unique case (req_data.kind)
                  frdq_pkg::KIND_RECEIVE: begin
                     state_in = ST_SCAN;
                     sidx_in = '0;
                     rd_pend_in = 1'b0;
                     hit_in = 1'b0;
                     free_ok_in = 1'b0;
                  end
                  frdq_pkg::KIND_LOCAL: begin
                     if (req_data.time_to_live != 4'd0) begin
                        local_id_in = local_id_ff + 8'd1;
                        req_in.origin_addr = node_address_ff;
                        req_in.frame_id = local_id_ff;
                        req_in.hop_count = 4'd0;
                        state_in = ST_ENQ;
                     end
                  end
                  frdq_pkg::KIND_TICK: begin
                     if (timer_ff) begin
                        if (countdown_ff > 16'd1) begin
                           countdown_in = countdown_ff - 16'd1;
                        end else begin
                           countdown_in = '0;
                           timer_in = 1'b0;
                           if (count_ff != '0) begin
                              state_in = ST_TREAD;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // issue read at sidx, examine data of previous read
            if (rd_pend_ff) begin
               if (s_rdata.valid) begin
                  if (!hit_ff && s_rdata.origin == req_ff.origin_addr) begin
                     hit_in = 1'b1;
                     hit_idx_in = SW'(sidx_ff - SCW'(1));
                     hit_ent_in = s_rdata;
                  end
               end else if (!free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_idx_in = SW'(sidx_ff - SCW'(1));
               end
            end
            if (sidx_ff == SCW'(SEEN_ENTRIES)) begin
               state_in = ST_DECIDE;
               rd_pend_in = 1'b0;
            end else begin
               rd_pend_in = 1'b1;
               sidx_in = sidx_ff + SCW'(1);
            end
         end
         ST_DECIDE: begin
            if (!hit_ff) begin
               is_new = 1'b1;
               if (free_ok_ff) begin
                  s_we = 1'b1;
                  s_waddr = free_idx_ff;
                  s_wdata = '{valid: 1'b1, origin: req_ff.origin_addr,
                              id: req_ff.frame_id, hops: req_ff.hop_count};
               end
            end else if (hit_ent_ff.id < req_ff.frame_id ||
                         (req_ff.frame_id == 8'd0 &&
                          hit_ent_ff.id > frdq_pkg::ID_WRAP_LIMIT)) begin
               is_new = 1'b1;
               s_we = 1'b1;
               s_waddr = hit_idx_ff;
               s_wdata = '{valid: 1'b1, origin: req_ff.origin_addr,
                           id: req_ff.frame_id, hops: req_ff.hop_count};
            end else if (hit_ent_ff.id == req_ff.frame_id &&
                         hit_ent_ff.hops < req_ff.hop_count) begin
               is_redeliver = 1'b1;
               s_we = 1'b1;
               s_waddr = hit_idx_ff;
               s_wdata = '{valid: 1'b1, origin: req_ff.origin_addr,
                           id: req_ff.frame_id, hops: req_ff.hop_count};
            end
            rsp_in = '0;
            rsp_in.result_kind = frdq_pkg::RESULT_DELIVER;
            rsp_in.out_origin = req_ff.origin_addr;
            rsp_in.out_id = req_ff.frame_id;
            rsp_in.out_hops = req_ff.hop_count;
            rsp_in.out_payload_ref = req_ff.payload_ref;
            if (is_redeliver) begin
               rsp_in.previous_hops = hit_ent_ff.hops;
               k_in = '0;
               qaddr_in = head_ff;
               rd_pend_in = 1'b0;
               state_in = ST_QSCAN;
            end else if (is_new) begin
               rsp_in.overflow = !free_ok_ff && !hit_ff;
               if (req_ff.time_to_live != 4'd0) begin
                  if (q_full) begin
                     rsp_in.overflow = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_ENQ;
                  end
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QSCAN: begin
            // read entry qaddr; next cycle modify and write
            q_raddr = qaddr_ff;
            if (k_ff >= count_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_QWRITE;
            end
         end
         ST_QWRITE: begin
            if (q_rdata.origin == req_ff.origin_addr && q_rdata.id == req_ff.frame_id) begin
               diff = 8'({4'd0, q_rdata.hops} - {4'd0, req_ff.hop_count});
               ent_ttl8 = {4'd0, q_rdata.ttl};
               q_we = 1'b1;
               q_waddr = qaddr_ff;
               q_wdata = q_rdata;
               q_wdata.hops = req_ff.hop_count;
               q_wdata.ttl = (diff > ent_ttl8) ? 4'd0 : 4'(ent_ttl8 - diff);
            end
            k_in = k_ff + CW'(1);
            qaddr_in = qinc(qaddr_ff);
            state_in = ST_QSCAN;
         end
         ST_ENQ: begin
            if (q_full) begin
               // only local requests reach here full
               rsp_in = '0;
               rsp_in.result_kind = frdq_pkg::RESULT_DELIVER;
               rsp_in.out_origin = req_ff.origin_addr;
               rsp_in.out_id = req_ff.frame_id;
               rsp_in.out_payload_ref = req_ff.payload_ref;
               rsp_in.overflow = 1'b1;
               state_in = ST_OUT;
            end else begin
               q_we = 1'b1;
               q_waddr = tail_ff;
               q_wdata = '{origin: req_ff.origin_addr, id: req_ff.frame_id,
                           hops: req_ff.hop_count, ttl: req_ff.time_to_live,
                           retx: 8'd0, pref: req_ff.payload_ref};
               tail_in = qinc(tail_ff);
               count_in = count_ff + CW'(1);
               if (!timer_ff) begin
                  timer_in = 1'b1;
                  countdown_in = period_eff;
               end
               state_in = (req_ff.kind == frdq_pkg::KIND_RECEIVE) ? ST_OUT : ST_IDLE;
            end
         end
         ST_TREAD: begin
            q_raddr = head_ff;
            state_in = ST_TSEND;
         end
         ST_TSEND: begin
            retx_nx = q_rdata.retx;
            state_in = ST_IDLE;
            if (q_rdata.ttl != 4'd0) begin
               rsp_in = '0;
               rsp_in.result_kind = frdq_pkg::RESULT_TRANSMIT;
               rsp_in.out_origin = q_rdata.origin;
               rsp_in.out_id = q_rdata.id;
               rsp_in.out_hops = q_rdata.hops + 4'd1;
               rsp_in.out_ttl = q_rdata.ttl - 4'd1;
               rsp_in.out_payload_ref = q_rdata.pref;
               state_in = ST_OUT;
               if (req_ff.send_accepted && q_rdata.retx != 8'd255) begin
                  retx_nx = q_rdata.retx + 8'd1;
               end
            end
            q_we = 1'b1;
            q_waddr = head_ff;
            q_wdata = q_rdata;
            q_wdata.retx = retx_nx;
            if (retx_nx >= max_retx_ff || q_rdata.ttl == 4'd0) begin
               head_in = qinc(head_ff);
               count_in = count_ff - CW'(1);
               if (count_ff != CW'(1)) begin
                  timer_in = 1'b1;
                  countdown_in = period_eff;
               end
            end else begin
               timer_in = 1'b1;
               countdown_in = period_eff;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         node_address_ff <= '0;
         max_retx_ff <= 8'd1;
         send_period_ff <= 16'd1;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         local_id_ff <= '0;
         countdown_ff <= '0;
         timer_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sidx_ff <= '0;
         rd_pend_ff <= 1'b0;
         hit_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         node_address_ff <= node_address_in;
         max_retx_ff <= max_retx_in;
         send_period_ff <= send_period_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         local_id_ff <= local_id_in;
         countdown_ff <= countdown_in;
         timer_ff <= timer_in;
         rsp_valid_ff <= rsp_valid_in;
         sidx_ff <= sidx_in;
         rd_pend_ff <= rd_pend_in;
         hit_ff <= hit_in;
         free_ok_ff <= free_ok_in;
         k_ff <= k_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      hit_idx_ff <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      hit_ent_ff <= hit_ent_in;
      qaddr_ff <= qaddr_in;
   end

endmodule

/* hdl/frdq_checker.sv */
// ---------------------------------------------------------------------------
// frdq_checker
// Port-level checks on the relay, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frdq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input frdq_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input frdq_pkg::rsp_type rsp_data
);

   `CHK_IMPLY(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled transaction changed")
   `CHK_ALWAYS(a_busy_while_out, clock, reset, !rsp_valid || req_stall, "request taken with result pending")
   `CHK_IMPLY(a_scan_after_take, clock, reset, req_valid && !req_stall && req_data.kind == frdq_pkg::KIND_RECEIVE |=> req_stall, "frame taken without table scan")
   `CHK_IMPLY(a_rsp_single, clock, reset, rsp_valid && !rsp_stall |=> !rsp_valid, "result repeated")
   `CHK_IMPLY(a_transmit_clean, clock, reset, rsp_valid && rsp_data.result_kind |-> !rsp_data.overflow && rsp_data.previous_hops == 4'd0, "transmit carries delivery fields")

endmodule

bind flood_relay_dedup_queue frdq_checker u_frdq_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the flooding relay: a behavioural copy of the
// origin table, send queue and send timer predicts every delivery and
// transmit; directed frames and local sends are followed by random traffic
// under bursty sending, patterned stalls and register changes between phases.
// ---------------------------------------------------------------------------
module tb;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   frdq_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   frdq_pkg::rsp_type rsp_data;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   flood_relay_dedup_queue u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // relay state copy
   frdq_pkg::seen_type origin_tbl [16];
   frdq_pkg::qent_type fwd_q [16];
   logic [3:0]  fwd_head, fwd_tail;
   int          fwd_count;
   logic [7:0]  local_id;
   logic [15:0] countdown;
   logic        timer_on;
   logic [15:0] own_addr;
   logic [7:0]  retx_limit;
   logic [15:0] period;

   frdq_pkg::req_type pending_tx [$];
   frdq_pkg::rsp_type expected_rsp [$];
   int      mismatches;
   int      accepted_tx;
   logic    hold_off;
   int      long_hold;
   logic    burst_on;
   int      burst_left;

   function automatic void start_timer();
      countdown = (period == 0) ? 16'd1 : period;
      timer_on  = 1'b1;
   endfunction

   function automatic bit push_fwd(logic [15:0] o, logic [7:0] id, logic [3:0] h,
                                   logic [3:0] t, logic [7:0] p);
      if (fwd_count >= 16) return 0;
      fwd_q[fwd_tail] = '{origin: o, id: id, hops: h, ttl: t, retx: 8'd0, pref: p};
      fwd_tail++;
      fwd_count++;
      if (!timer_on) start_timer();
      return 1;
   endfunction

   function automatic void predict_relay(frdq_pkg::req_type r);
      frdq_pkg::rsp_type res;
      int       hit, free_slot;
      bit       fresh, ovf;
      logic [7:0] diff;
      logic [3:0] idx;
      res   = '0;
      fresh = 0;
      ovf   = 0;
      case (r.kind)
         frdq_pkg::KIND_RECEIVE: begin
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < 16; i++) begin
               if (origin_tbl[i].valid) begin
                  if (hit < 0 && origin_tbl[i].origin == r.origin_addr) hit = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit < 0) begin
               fresh = 1;
               if (free_slot >= 0)
                  origin_tbl[free_slot] = '{1'b1, r.origin_addr, r.frame_id, r.hop_count};
               else
                  ovf = 1;
            end else if (origin_tbl[hit].id < r.frame_id ||
                         (r.frame_id == 0 &&
                          origin_tbl[hit].id > frdq_pkg::ID_WRAP_LIMIT)) begin
               fresh = 1;
               origin_tbl[hit].id   = r.frame_id;
               origin_tbl[hit].hops = r.hop_count;
            end else if (origin_tbl[hit].id == r.frame_id &&
                         origin_tbl[hit].hops < r.hop_count) begin
               res = '{frdq_pkg::RESULT_DELIVER, r.origin_addr, r.frame_id, r.hop_count,
                       origin_tbl[hit].hops, 4'd0, r.payload_ref, 1'b0};
               for (int k = 0; k < fwd_count; k++) begin
                  idx = fwd_head + 4'(k);
                  if (fwd_q[idx].origin == r.origin_addr && fwd_q[idx].id == r.frame_id) begin
                     diff = 8'(8'(fwd_q[idx].hops) - 8'(r.hop_count));
                     fwd_q[idx].hops = r.hop_count;
                     fwd_q[idx].ttl  = (diff > fwd_q[idx].ttl) ? 4'd0
                                       : 4'(fwd_q[idx].ttl - diff);
                  end
               end
               origin_tbl[hit].hops = r.hop_count;
               expected_rsp.push_back(res);
               return;
            end
            if (!fresh) return;
            if (r.time_to_live != 0 &&
                !push_fwd(r.origin_addr, r.frame_id, r.hop_count, r.time_to_live,
                          r.payload_ref))
               ovf = 1;
            res = '{frdq_pkg::RESULT_DELIVER, r.origin_addr, r.frame_id, r.hop_count,
                    4'd0, 4'd0, r.payload_ref, ovf};
            expected_rsp.push_back(res);
         end
         frdq_pkg::KIND_LOCAL: begin
            if (r.time_to_live == 0) return;
            res = '{frdq_pkg::RESULT_DELIVER, own_addr, local_id, 4'd0, 4'd0, 4'd0,
                    r.payload_ref, 1'b1};
            local_id++;
            if (!push_fwd(own_addr, res.out_id, 4'd0, r.time_to_live, r.payload_ref))
               expected_rsp.push_back(res);
         end
         frdq_pkg::KIND_TICK: begin
            if (!timer_on) return;
            if (countdown > 1) begin
               countdown--;
               return;
            end
            countdown = 0;
            timer_on  = 0;
            if (fwd_count == 0) return;
            if (fwd_q[fwd_head].ttl > 0) begin
               expected_rsp.push_back('{frdq_pkg::RESULT_TRANSMIT, fwd_q[fwd_head].origin,
                  fwd_q[fwd_head].id, fwd_q[fwd_head].hops + 4'd1, 4'd0,
                  fwd_q[fwd_head].ttl - 4'd1, fwd_q[fwd_head].pref, 1'b0});
               if (r.send_accepted && fwd_q[fwd_head].retx < 255)
                  fwd_q[fwd_head].retx++;
            end
            if (fwd_q[fwd_head].retx >= retx_limit || fwd_q[fwd_head].ttl == 0) begin
               fwd_head++;
               fwd_count--;
            end
            if (fwd_count != 0) start_timer();
         end
         default: ;
      endcase
   endfunction

   function automatic frdq_pkg::req_type make_tx(logic [1:0] k, logic [15:0] o,
                                                 logic [7:0] id, logic [3:0] h,
                                                 logic [3:0] t, logic [7:0] p,
                                                 logic a);
      return '{k, o, id, h, t, p, a};
   endfunction

   // random item drawn from a small origin pool so repeats and wraps occur
   function automatic frdq_pkg::req_type random_tx();
      frdq_pkg::req_type r;
      int      sel;
      r = frdq_pkg::req_type'({$urandom, $urandom});
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         r.kind = frdq_pkg::KIND_RECEIVE;
         if ($urandom_range(0, 9) < 8) r.origin_addr = 16'($urandom_range(0, 11));
         if ($urandom_range(0, 3) == 0) r.frame_id = 8'($urandom_range(236, 255));
         else if ($urandom_range(0, 3) == 0) r.frame_id = 8'($urandom_range(0, 3));
      end else if (sel < 55) begin
         r.kind = frdq_pkg::KIND_LOCAL;
      end else if (sel < 98) begin
         r.kind = frdq_pkg::KIND_TICK;
      end else begin
         r.kind = 2'd3;
      end
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (burst_left == 0) begin
            burst_on   = ($urandom_range(0, 2) != 0);
            burst_left = $urandom_range(1, 30);
         end
         burst_left--;
         if (burst_on && pending_tx.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_tx.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 15) < (($urandom_range(0, 1)) ? 0 : 6));
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_relay(req_data);
         accepted_tx++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", rsp_data);
         end else if (rsp_data !== expected_rsp[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p actual %p", expected_rsp[0], rsp_data);
            void'(expected_rsp.pop_front());
         end else begin
            void'(expected_rsp.pop_front());
         end
      end
   end

   task automatic csr_set(logic [1:0] idx, logic [15:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         frdq_pkg::CSR_NODE_ADDRESS:    own_addr   = v;
         frdq_pkg::CSR_MAX_RETRANSMITS: retx_limit = v[7:0];
         frdq_pkg::CSR_SEND_PERIOD:     period     = v;
         default: ;
      endcase
   endtask

   task automatic drain_all();
      int target;
      target = accepted_tx + pending_tx.size();
      while (accepted_tx < target || expected_rsp.size() > 0 || req_valid || req_stall)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = frdq_pkg::CSR_NODE_ADDRESS;
      csr_data  = '0;
      hold_off = 1'b0;
      long_hold = 0;
      burst_on = 1'b1;
      burst_left = 0;
      mismatches = 0;
      accepted_tx = 0;
      foreach (origin_tbl[i]) origin_tbl[i] = '0;
      foreach (fwd_q[i]) fwd_q[i] = '0;
      fwd_head = 0; fwd_tail = 0; fwd_count = 0;
      local_id = 0; countdown = 0; timer_on = 0;
      own_addr = 0; retx_limit = 8'd1; period = 16'd1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (40) @(posedge clock);

      csr_set(frdq_pkg::CSR_NODE_ADDRESS, 16'hFFFF);
      csr_set(frdq_pkg::CSR_MAX_RETRANSMITS, 16'd2);
      csr_set(frdq_pkg::CSR_SEND_PERIOD, 16'd1);
      // directed: extremes, wrap to 0, repeat with more hops, ttl 0, kind 3
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'h0000, 8'd0, 4'd0, 4'd15,
                                   8'h00, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'hFFFF, 8'd255, 4'd15, 4'd1,
                                   8'hFF, 1'b1));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'h0000, 8'd0, 4'd3, 4'd5,
                                   8'h11, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'h0000, 8'd0, 4'd1, 4'd5,
                                   8'h12, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'h0000, 8'd241, 4'd2, 4'd0,
                                   8'h13, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'h0000, 8'd0, 4'd2, 4'd3,
                                   8'h14, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'h0000, 8'd5, 4'd2, 4'd3,
                                   8'h15, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'h0000, 8'd4, 4'd2, 4'd3,
                                   8'h16, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_LOCAL, 16'h1234, 8'd9, 4'd9, 4'd0,
                                   8'h20, 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_LOCAL, 16'h1234, 8'd9, 4'd9, 4'd15,
                                   8'h21, 1'b1));
      pending_tx.push_back(make_tx(2'd3, 16'hFFFF, 8'hFF, 4'hF, 4'hF, 8'hFF, 1'b1));
      for (int i = 0; i < 6; i++)
         pending_tx.push_back(make_tx(frdq_pkg::KIND_TICK, 16'h0, 8'h0, 4'h0, 4'h0, 8'h0,
                                      i[0]));
      // fill the origin table past capacity and the queue past full
      for (int i = 0; i < 18; i++)
         pending_tx.push_back(make_tx(frdq_pkg::KIND_RECEIVE, 16'(100 + i), 8'd1, 4'd0,
                                      4'd2, 8'(i), 1'b0));
      pending_tx.push_back(make_tx(frdq_pkg::KIND_LOCAL, 16'h0, 8'h0, 4'h0, 4'd1, 8'h77,
                                   1'b0));
      drain_all();
      for (int i = 0; i < 60; i++)
         pending_tx.push_back(make_tx(frdq_pkg::KIND_TICK, 16'h0, 8'h0, 4'h0, 4'h0, 8'h0,
                                      1'b1));
      drain_all();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               csr_set(frdq_pkg::CSR_MAX_RETRANSMITS, 16'd0);
               csr_set(frdq_pkg::CSR_SEND_PERIOD, 16'd0);
            end
            1: begin
               csr_set(frdq_pkg::CSR_MAX_RETRANSMITS, 16'd255);
               csr_set(frdq_pkg::CSR_SEND_PERIOD, 16'd3);
            end
            2: begin
               csr_set(frdq_pkg::CSR_NODE_ADDRESS, 16'h0000);
               csr_set(frdq_pkg::CSR_SEND_PERIOD, 16'hFFFF);
            end
            3: begin
               csr_set(frdq_pkg::CSR_MAX_RETRANSMITS, 16'd1);
               csr_set(frdq_pkg::CSR_SEND_PERIOD, 16'd2);
            end
            default: begin
               csr_set(frdq_pkg::CSR_NODE_ADDRESS, 16'($urandom));
               csr_set(frdq_pkg::CSR_MAX_RETRANSMITS, 16'($urandom_range(0, 4)));
               csr_set(frdq_pkg::CSR_SEND_PERIOD, 16'd1);
            end
         endcase
         for (int i = 0; i < 320; i++) pending_tx.push_back(random_tx());
         if (ph == 1) begin
            // hold results off while traffic keeps arriving
            target = accepted_tx + 100;
            long_hold = 400;
            while (accepted_tx < target && pending_tx.size() > 0) @(posedge clock);
         end
         if (ph == 3) begin
            // pause the sender until every result is in
            target = accepted_tx + pending_tx.size() - 150;
            while (accepted_tx < target) @(posedge clock);
            pending_tx.insert(0, make_tx(frdq_pkg::KIND_TICK, 16'h0, 8'h0, 4'h0, 4'h0, 8'h0,
                                         1'b1));
            begin
               frdq_pkg::req_type held [$];
               held = pending_tx;
               pending_tx.delete();
               drain_all();
               pending_tx = held;
            end
         end
         drain_all();
      end

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

/* flood_relay_dedup_queue.f */
+incdir+hdl
hdl/frdq_pkg.sv
hdl/frdq_ram.sv
hdl/flood_relay_dedup_queue.sv
hdl/frdq_checker.sv
test/tb.sv
